// ----- design/uprb_pkg.sv -----
// ----------------------------------------------------------------------------
// uprb_pkg: shared types and constants for the unicycle pose range bearing block
// holds the cordic angle table, register indexes and controller states
// ----------------------------------------------------------------------------
package uprb_pkg;

  localparam int unsigned MaxLandmarksDef = 16;
  localparam int unsigned CordicItersDef  = 16;
  localparam int unsigned AtanLen         = 24;
  localparam logic [29:0] InvGain         = 30'd652032874;

  typedef enum logic [2:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_START_HEAD  = 3'd2,
    REG_SPEED       = 3'd3,
    REG_TURN_RATE   = 3'd4,
    REG_STEP_TIME   = 3'd5,
    REG_STEP_LIMIT  = 3'd6,
    REG_LM_COUNT    = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOT_MUL,
    ST_MOT_GAIN,
    ST_ROT,
    ST_POSE,
    ST_RD,
    ST_VEC_LOAD,
    ST_VEC,
    ST_GAIN,
    ST_OUT,
    ST_FIN
  } state_e;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/unicycle_pose_range_bearing_top.sv -----
// ----------------------------------------------------------------------------
// unicycle_pose_range_bearing_top: unicycle pose integrator with range/bearing
// sensor over a landmark table held in a synchronous ram
// ----------------------------------------------------------------------------
// a landmark write goes into the ram while idle; a finished tick loads only a finished result
// a stepping tick: motion first (gain multiply, cordic rotation, pose update), then per landmark
//   a ram read, cordic vectoring, gain multiply and output load, with no vectoring when the
//   landmark sits on the robot, plus any wait for the output register to drain
// one item at a time: the input is taken only while idle, and the single shared iterative
//   cordic unit serves the motion step and every landmark
// reset: pose clears to zero, step counter clears, landmark ram undefined
module unicycle_pose_range_bearing_top
  import uprb_pkg::*;
#(
  parameter int unsigned MAX_LANDMARKS = MaxLandmarksDef,
  parameter int unsigned CORDIC_ITERS  = CordicItersDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // landmark_slot[3:0], landmark_x[35:4], landmark_y[67:36]
  input  logic         s_axis_tuser,  // action
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // result_slot, distance, bearing, pose_x, pose_y,
                                      // pose_heading, zero fill
  output logic         m_axis_tlast,  // last
  output logic         m_axis_tuser   // finished
);
  localparam int unsigned AddrW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int unsigned CntMax = (MAX_LANDMARKS < 16) ? MAX_LANDMARKS : 16;

  // configuration registers
  logic signed [31:0] speed_q, turn_q;
  logic [15:0] dt_q;
  logic [31:0] limit_q;
  logic [4:0]  lmcnt_q;

  // pose state
  logic signed [31:0] px_q, py_q;
  logic [31:0] phase_q, steps_q;

  // control
  state_e state_q, state_d;
  logic [4:0] idx_q;
  logic [4:0] nlm_q;
  logic signed [47:0] mul_q;
  logic signed [63:0] gain_q;
  logic [31:0] z_save_q;

  // output register
  logic         ov_q;
  logic [135:0] od_q;
  logic         ol_q, of_q;

  logic in_acc, out_acc, out_load;
  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign out_acc = m_axis_tvalid & m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  // output register takes a new transaction when empty or draining this cycle
  assign out_load = ((state_q == ST_GAIN) || (state_q == ST_FIN)) && (!ov_q || out_acc);

  logic       in_act;
  logic [3:0] in_slot;
  assign in_act  = s_axis_tuser;
  assign in_slot = s_axis_tdata[3:0];

  // landmark ram: x high half, y low half
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [63:0]      ram_rd;
  assign ram_we   = in_acc & in_act & (7'(in_slot) < 7'(MAX_LANDMARKS));
  assign ram_addr = (state_q == ST_IDLE) ? AddrW'(in_slot) : AddrW'(idx_q);

  uprb_ram #(.Width(64), .Depth(MAX_LANDMARKS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i ({s_axis_tdata[35:4], s_axis_tdata[67:36]}),
    .rdata_o (ram_rd)
  );

  // cordic
  logic c_start, c_vec, c_done;
  logic signed [35:0] c_xi, c_yi, c_xo, c_yo;
  logic [31:0] c_zi, c_zo;

  uprb_cordic #(.CordicIters(CORDIC_ITERS)) u_cordic (
    .clk_i, .rst_ni,
    .start_i    (c_start),
    .vec_mode_i (c_vec),
    .x_i        (c_xi),
    .y_i        (c_yi),
    .z_i        (c_zi),
    .done_o     (c_done),
    .x_o        (c_xo),
    .y_o        (c_yo),
    .z_o        (c_zo)
  );

  // rotation prep: fold phase into [-pi/2, pi/2)
  logic [31:0] ph_shift;
  logic        fold;
  logic signed [35:0] mag36;
  assign ph_shift = phase_q + 32'h40000000;
  assign fold     = ph_shift[31];
  assign mag36    = 36'(gain_q >>> 30);

  // vectoring prep
  logic signed [32:0] ldx, ldy;
  logic               vneg, vzero;
  assign ldx   = 33'(signed'(ram_rd[63:32])) - 33'(px_q);
  assign ldy   = 33'(signed'(ram_rd[31:0])) - 33'(py_q);
  assign vzero = (ldx == 33'sd0) && (ldy == 33'sd0);
  assign vneg  = ldx[32];

  always_comb begin
    c_start = 1'b0;
    c_vec   = 1'b0;
    c_xi    = '0;
    c_yi    = '0;
    c_zi    = '0;
    case (state_q)
      ST_MOT_GAIN: begin
        c_start = 1'b1;
        c_xi    = fold ? -mag36 : mag36;
        c_zi    = fold ? phase_q + 32'h80000000 : phase_q;
      end
      ST_VEC_LOAD: begin
        c_start = ~vzero;
        c_vec   = 1'b1;
        c_xi    = vneg ? -36'(ldx) : 36'(ldx);
        c_yi    = vneg ? -36'(ldy) : 36'(ldy);
        c_zi    = vneg ? 32'h80000000 : 32'h0;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:
        if (in_acc && !in_act) begin
          state_d = (steps_q >= limit_q) ? ST_FIN : ST_MOT_MUL;
        end
      ST_MOT_MUL:  state_d = ST_MOT_GAIN;
      ST_MOT_GAIN: state_d = ST_ROT;
      ST_ROT:      if (c_done) state_d = ST_POSE;
      ST_POSE:     state_d = ST_RD;
      ST_RD:       state_d = ST_VEC_LOAD;
      ST_VEC_LOAD: state_d = vzero ? ST_GAIN : ST_VEC;
      ST_VEC:      if (c_done) state_d = ST_GAIN;
      ST_GAIN:     if (!ov_q || out_acc) state_d = ST_OUT;
      ST_OUT: begin
        state_d = (idx_q + 5'd1 == nlm_q) ? ST_IDLE : ST_RD;
      end
      ST_FIN:      if (!ov_q || out_acc) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // magnitude gain product, signed 36x30
  logic signed [65:0] rng_full;
  assign rng_full = 66'(c_xo) * 66'(signed'({1'b0, InvGain}));

  logic signed [32:0] sum_x, sum_y;
  assign sum_x = 33'(px_q) + 33'(c_xo);
  assign sum_y = 33'(py_q) + 33'(c_yo);

  function automatic logic [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sd2147483647)       return 32'h7FFFFFFF;
    else if (v < -33'sd2147483648) return 32'h80000000;
    else                           return v[31:0];
  endfunction

  logic [4:0] cnt_clamped;
  always_comb begin
    cnt_clamped = (lmcnt_q == 5'd0) ? 5'd1 : lmcnt_q;
    if (cnt_clamped > 5'(CntMax)) cnt_clamped = 5'(CntMax);
  end

  logic signed [63:0] rng_sh;
  logic [31:0]        range_v, bear_v;
  assign rng_sh  = 64'(gain_q >>> 30);
  assign range_v = rng_sh[63] ? 32'h0 :
                   (rng_sh > 64'sh00000000FFFFFFFF) ? 32'hFFFFFFFF : rng_sh[31:0];
  assign bear_v  = (z_save_q - phase_q) + 32'h8000;

  // datapath and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q    <= '0;
      py_q    <= '0;
      phase_q <= '0;
      steps_q <= '0;
      speed_q <= '0;
      turn_q  <= '0;
      dt_q    <= 16'd655;
      limit_q <= 32'd1000;
      lmcnt_q <= 5'd1;
      idx_q   <= '0;
      nlm_q   <= 5'd1;
      ov_q    <= 1'b0;
      ol_q    <= 1'b0;
      of_q    <= 1'b0;
    end else begin
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_acc) begin
        ov_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_START_X:    px_q    <= cfg_data_i;
          REG_START_Y:    py_q    <= cfg_data_i;
          REG_START_HEAD: phase_q <= {cfg_data_i[15:0], 16'h0};
          REG_SPEED:      speed_q <= cfg_data_i;
          REG_TURN_RATE:  turn_q  <= cfg_data_i;
          REG_STEP_TIME:  dt_q    <= cfg_data_i[15:0];
          REG_STEP_LIMIT: limit_q <= cfg_data_i;
          REG_LM_COUNT:   lmcnt_q <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && !in_act && steps_q < limit_q) steps_q <= steps_q + 32'd1;
          idx_q <= '0;
          nlm_q <= cnt_clamped;
        end
        ST_POSE: begin
          px_q    <= sat32(sum_x);
          py_q    <= sat32(sum_y);
          phase_q <= phase_q + 32'(mul_q >>> 16);
        end
        ST_GAIN: if (out_load) begin
          ol_q <= (idx_q + 5'd1 == nlm_q);
          of_q <= 1'b0;
        end
        ST_OUT: idx_q <= idx_q + 5'd1;
        ST_FIN: if (out_load) begin
          ol_q <= 1'b1;
          of_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE:     mul_q <= 48'(speed_q) * 48'(signed'({1'b0, dt_q}));
      ST_MOT_MUL: begin
        gain_q <= 64'(mul_q >>> 16) * 64'(signed'({1'b0, InvGain}));
        mul_q  <= 48'(turn_q) * 48'(signed'({1'b0, dt_q}));
      end
      ST_VEC_LOAD: if (vzero) begin
        gain_q   <= '0;
        z_save_q <= '0;
      end
      ST_VEC: if (c_done) begin
        gain_q   <= rng_full[63:0];
        z_save_q <= c_zo;
      end
      ST_GAIN: if (out_load) begin
        od_q <= {4'h0, phase_q[31:16], py_q, px_q, bear_v[31:16], range_v, idx_q[3:0]};
      end
      ST_FIN: if (out_load) begin
        od_q <= {4'h0, phase_q[31:16], py_q, px_q, 16'h0, 32'h0, 4'h0};
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = of_q;
endmodule

// ----- design/uprb_ram.sv -----
// ----------------------------------------------------------------------------
// uprb_ram: generic single port ram
// one write and one read per cycle on the shared address, registered read data
// ----------------------------------------------------------------------------
module uprb_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- design/uprb_cordic.sv -----
// ----------------------------------------------------------------------------
// uprb_cordic: iterative cordic, rotation and vectoring modes
// one micro-rotation per cycle on 36-bit datapath
// ----------------------------------------------------------------------------
module uprb_cordic
  import uprb_pkg::*;
#(
  parameter int unsigned CordicIters = CordicItersDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               vec_mode_i,
  input  logic signed [35:0] x_i,
  input  logic signed [35:0] y_i,
  input  logic [31:0]        z_i,
  output logic               done_o,
  output logic signed [35:0] x_o,
  output logic signed [35:0] y_o,
  output logic [31:0]        z_o
);
  localparam int unsigned NIters = (CordicIters < AtanLen) ? CordicIters : AtanLen;
  localparam logic [4:0]  LastIt = 5'(NIters - 1);

  logic signed [35:0] x_q, y_q;
  logic [31:0] z_q;
  logic [4:0]  it_q;
  logic        busy_q, mode_q, done_q;
  logic signed [35:0] dx, dy;
  logic        up;
  logic [31:0] a;

  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign a  = atan_lut(it_q);
  // rotation: direction by sign of residual angle; vectoring: by sign of y
  assign up = mode_q ? (y_q > 36'sd0) : ~z_q[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
      mode_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= '0;
        mode_q <= vec_mode_i;
      end else if (busy_q) begin
        it_q <= it_q + 5'd1;
        if (it_q == LastIt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
    end else if (busy_q) begin
      if (mode_q) begin
        if (up) begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + a;
        end else begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - a;
        end
      end else begin
        if (up) begin
          x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - a;
        end else begin
          x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + a;
        end
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
endmodule

// ----- design/uprb_checker.sv -----
// ----------------------------------------------------------------------------
// uprb_sva_checker: port level checks for the unicycle pose range bearing block
// watches handshake and result framing
// ----------------------------------------------------------------------------
module uprb_sva_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic         m_axis_tlast,
  input logic         m_axis_tuser
);
  // output transaction held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // finished result is always the last one of its tick
  a_fin_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("finished result without last");

  // finished result carries slot zero and zero distance
  a_fin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[35:0] == 36'h0)
    else $error("finished result carries data");

  // no new input taken while a tick is producing results mid-run
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken during a tick");
endmodule

bind unicycle_pose_range_bearing_top uprb_sva_checker u_uprb_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
);

// ----- verif/uprb_checker.sv -----
// ----------------------------------------------------------------------------
// uprb_checker: scoreboard for the unicycle pose range bearing block
// mirrors config writes and input transactions into a fixed-point pose and
// sensor model, queues the predicted measurements and compares each output
// transaction with the oldest one
// ----------------------------------------------------------------------------
module uprb_checker
  import uprb_pkg::*;
(
  input  logic         clk_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  input  logic [71:0]  s_tdata_i,
  input  logic         s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  input  logic [135:0] m_tdata_i,
  input  logic         m_tlast_i,
  input  logic         m_tuser_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           steps_o,
  output int           meas_count_o,
  output int           finished_count_o
);
  localparam longint Gain = 64'd652032874;
  localparam int     Iters = 16;

  typedef struct packed {
    logic [3:0]  slot;
    logic [31:0] distance;
    logic [15:0] bear;
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] ph;
    logic        last;
    logic        fin;
  } meas_t;

  logic [31:0] angle_step [Iters] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // mirrored configuration and pose
  logic [31:0] speed = '0, turn_rate = '0, step_limit = 32'd1000;
  logic [15:0] step_time = 16'd655;
  logic [4:0]  lm_count = 5'd1;
  logic [31:0] pos_x = '0, pos_y = '0, steps_done = '0;
  logic [31:0] phase = '0;
  logic [63:0] lm_table [16];

  meas_t expected_meas [$];

  int fails = 0, meas_seen = 0, fin_seen = 0;

  assign fail_count_o     = fails;
  assign steps_o          = int'(steps_done);
  assign meas_count_o     = meas_seen;
  assign finished_count_o = fin_seen;

  function automatic logic [31:0] sat_s32(input longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic void rotate(input longint mag, input logic [31:0] ph,
                                 output longint ox, output longint oy);
    longint x, y, z, dx, dy;
    logic [31:0] p, q;
    x = mag;
    y = 0;
    p = ph;
    q = ph + 32'h40000000;
    // fold the left half plane onto the right one
    if (q[31]) begin
      x = -x;
      p = ph + 32'h80000000;
    end
    z = longint'($signed(p));
    for (int i = 0; i < Iters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(angle_step[i]);
      end else begin
        x += dx; y -= dy; z += longint'(angle_step[i]);
      end
    end
    ox = x;
    oy = y;
  endfunction

  function automatic void vectorize(input longint xi, input longint yi,
                                    output logic [31:0] rng, output logic [31:0] ang);
    longint x, y, dx, dy, m;
    logic [31:0] z;
    x = xi;
    y = yi;
    z = '0;
    if (x == 0 && y == 0) begin
      rng = '0;
      ang = '0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < Iters; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += angle_step[i];
      end else begin
        x -= dx; y += dy; z -= angle_step[i];
      end
    end
    m = (x * Gain) >>> 30;
    if (m < 0) m = 0;
    if (m > 64'sh0FFFFFFFF) m = 64'sh0FFFFFFFF;
    rng = m[31:0];
    ang = z;
  endfunction

  task automatic predict_tick();
    longint d, mag, cx, cy, t;
    logic [31:0] rng, ang, br;
    int n;
    meas_t e;
    if (steps_done >= step_limit) begin
      e = '{slot: 4'd0, distance: 32'd0, bear: 16'd0, px: pos_x, py: pos_y,
            ph: phase[31:16], last: 1'b1, fin: 1'b1};
      expected_meas = {expected_meas, e};
      return;
    end
    steps_done++;
    // move along the old heading
    d   = (longint'($signed(speed)) * longint'(step_time)) >>> 16;
    mag = (d * Gain) >>> 30;
    rotate(mag, phase, cx, cy);
    pos_x = sat_s32(longint'($signed(pos_x)) + cx);
    pos_y = sat_s32(longint'($signed(pos_y)) + cy);
    t = (longint'($signed(turn_rate)) * longint'(step_time)) >>> 16;
    phase += t[31:0];
    n = (lm_count == 0) ? 1 : (lm_count > 16 ? 16 : int'(lm_count));
    for (int i = 0; i < n; i++) begin
      vectorize(longint'($signed(lm_table[i][63:32])) - longint'($signed(pos_x)),
                longint'($signed(lm_table[i][31:0])) - longint'($signed(pos_y)), rng, ang);
      br = (ang - phase) + 32'h8000;
      e = '{slot: i[3:0], distance: rng, bear: br[31:16], px: pos_x, py: pos_y,
            ph: phase[31:16], last: (i == n - 1), fin: 1'b0};
      expected_meas = {expected_meas, e};
    end
  endtask

  always @(posedge clk_i) begin
    meas_t got, want;
    if (cfg_valid_i && cfg_ready_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_START_X:    pos_x = cfg_data_i;
        REG_START_Y:    pos_y = cfg_data_i;
        REG_START_HEAD: phase = {cfg_data_i[15:0], 16'h0};
        REG_SPEED:      speed = cfg_data_i;
        REG_TURN_RATE:  turn_rate = cfg_data_i;
        REG_STEP_TIME:  step_time = cfg_data_i[15:0];
        REG_STEP_LIMIT: step_limit = cfg_data_i;
        REG_LM_COUNT:   lm_count = cfg_data_i[4:0];
        default: ;
      endcase
    end
    if (s_tvalid_i && s_tready_i) begin
      if (s_tuser_i) begin
        lm_table[s_tdata_i[3:0]] = {s_tdata_i[35:4], s_tdata_i[67:36]};
      end else begin
        predict_tick();
      end
    end
    if (m_tvalid_i && m_tready_i) begin
      got = '{slot: m_tdata_i[3:0], distance: m_tdata_i[35:4], bear: m_tdata_i[51:36],
              px: m_tdata_i[83:52], py: m_tdata_i[115:84], ph: m_tdata_i[131:116],
              last: m_tlast_i, fin: m_tuser_i};
      meas_seen++;
      if (m_tuser_i) fin_seen++;
      if (expected_meas.size() == 0) begin
        fails++;
        $display("%0t: unexpected measurement %p", $time, got);
      end else begin
        want = expected_meas.pop_front();
        if (got != want) begin
          fails++;
          $display("%0t: measurement mismatch, expected %p, actual %p", $time, want, got);
        end
      end
    end
    pending_o <= expected_meas.size();
  end

endmodule

// ----- verif/unicycle_pose_range_bearing_top_tb.sv -----
// ----------------------------------------------------------------------------
// unicycle_pose_range_bearing_top_tb: stimulus and verdict for the pose block
// writes landmarks and ticks through the input stream under bursty traffic and
// a stalling receiver, sweeps configurations between drained phases, and
// leaves prediction and comparison to the checker
// ----------------------------------------------------------------------------
module unicycle_pose_range_bearing_top_tb
  import uprb_pkg::*;
;
  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;  // landmark_slot, landmark_x, landmark_y, zero fill
  logic         s_axis_tuser = 1'b0; // action
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;       // result_slot, distance, bearing, pose_x, pose_y,
                                    // pose_heading, zero fill
  logic         m_axis_tlast;       // last
  logic         m_axis_tuser;       // finished

  int fail_count, pending, steps, meas_count, fin_count;

  // sender burst bookkeeping
  int burst_left = 0;
  int ticks_sent = 0, writes_sent = 0;

  // receiver long hold-off request
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  localparam logic ActTick  = 1'b0;
  localparam logic ActWrite = 1'b1;

  always #5 clk_i = ~clk_i;

  unicycle_pose_range_bearing_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  uprb_checker u_checker (
    .clk_i            (clk_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tdata_i        (s_axis_tdata),
    .s_tuser_i        (s_axis_tuser),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .m_tlast_i        (m_axis_tlast),
    .m_tuser_i        (m_axis_tuser),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .steps_o          (steps),
    .meas_count_o     (meas_count),
    .finished_count_o (fin_count)
  );

  // receiver: a changing stall pattern, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 3000;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(16, 120);
      end
      mode_left--;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;                       // no stalls
        1:       m_axis_tready <= $urandom_range(0, 1);       // heavy stalling
        default: m_axis_tready <= ($urandom_range(0, 7) != 0); // light stalling
      endcase
    end
  end

  // one input transaction; valid stays high across items within a burst
  task automatic send_item(input logic act, input logic [3:0] slot,
                           input logic [31:0] lx, input logic [31:0] ly);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'h0, ly, lx, slot};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ActTick) ticks_sent++;
    else writes_sent++;
  endtask

  task automatic send_tick();
    send_item(ActTick, 4'($urandom), $urandom, $urandom); // payload ignored on ticks
  endtask

  task automatic send_landmark(input logic [3:0] slot, input logic [31:0] lx,
                               input logic [31:0] ly);
    send_item(ActWrite, slot, lx, ly);
  endtask

  // stop sending and wait until every predicted measurement has come out,
  // then allow the block to finish any landmark write still in flight
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      2:       return $urandom_range(0, 32'h0003FFFF) - 32'h00020000; // near origin
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_speed();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      default: return $urandom_range(0, 32'h00FFFFFF) - 32'h00800000;
    endcase
  endfunction

  initial begin
    logic [31:0] lim;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: fill the whole landmark table first so no tick reads an empty slot
    send_landmark(4'd0, 32'h0, 32'h0);               // sits on the reset pose
    send_landmark(4'd1, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_landmark(4'd2, 32'h80000000, 32'h80000000);
    send_landmark(4'd3, 32'h7FFFFFFF, 32'h80000000);
    send_landmark(4'd4, 32'h80000000, 32'h7FFFFFFF);
    send_landmark(4'd5, 32'h00010000, 32'h0);        // straight ahead
    send_landmark(4'd6, 32'hFFFF0000, 32'h0);        // straight behind
    for (int s = 7; s < 16; s++) send_landmark(4'(s), $urandom, $urandom);
    send_tick();                                     // landmark at robot, stationary
    drain();

    // directed: extreme motion over all landmarks
    cfg_write(REG_START_X, 32'h80000000);
    cfg_write(REG_START_Y, 32'h7FFFFFFF);
    cfg_write(REG_START_HEAD, 32'h00008000);
    cfg_write(REG_SPEED, 32'h7FFFFFFF);
    cfg_write(REG_TURN_RATE, 32'h7FFFFFFF);
    cfg_write(REG_STEP_TIME, 32'h0000FFFF);
    cfg_write(REG_STEP_LIMIT, 32'hFFFFFFFF);
    cfg_write(REG_LM_COUNT, 32'd16);
    repeat (2) send_tick();
    drain();
    cfg_write(REG_SPEED, 32'h80000000);
    cfg_write(REG_TURN_RATE, 32'h80000000);
    cfg_write(REG_STEP_TIME, 32'd1);
    cfg_write(REG_LM_COUNT, 32'd0);                  // zero count behaves as one
    repeat (2) send_tick();
    drain();

    // directed: step limit reached exactly, then ticks that only report finished
    cfg_write(REG_STEP_LIMIT, 32'(steps + 1));
    cfg_write(REG_LM_COUNT, 32'd31);                 // above the table size
    cfg_write(REG_STEP_TIME, 32'd655);
    repeat (3) send_tick();
    drain();
    cfg_write(REG_STEP_LIMIT, 32'd0);
    send_tick();
    drain();

    // random phases: new settings, then a mix of landmark updates and ticks
    for (int ph = 0; ph < 11; ph++) begin
      cfg_write(REG_START_X, pick_word());
      cfg_write(REG_START_Y, pick_word());
      cfg_write(REG_START_HEAD, $urandom);
      cfg_write(REG_SPEED, pick_speed());
      cfg_write(REG_TURN_RATE, $urandom_range(0, 3) == 0 ? $urandom
                                                         : $urandom_range(0, 32'h00FFFFFF) -
                                                           32'h00800000);
      cfg_write(REG_STEP_TIME, $urandom_range(0, 3) == 0 ? 32'd65535
                                                         : $urandom_range(1, 65535));
      case ($urandom_range(0, 7))
        0:       lim = 32'd0;
        1:       lim = 32'(steps + $urandom_range(0, 10));
        default: lim = 32'hFFFFFFFF;
      endcase
      cfg_write(REG_STEP_LIMIT, lim);
      // mostly few landmarks to keep ticks short, sometimes the full table
      cfg_write(REG_LM_COUNT, $urandom_range(0, 3) == 0 ? 32'd16 : $urandom_range(1, 6));
      if (ph == 4) hold_req = 1'b1;                  // sender keeps pushing into a full block
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 3) == 0) send_landmark(4'($urandom), pick_word(), pick_word());
        else send_tick();
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("summary: %0d ticks (%0d steps taken), %0d landmark writes, %0d measurements",
             ticks_sent, steps, writes_sent, meas_count);
    $display("summary: %0d finished reports, pending at end %0d", fin_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending != 0) $display("%0t: %0d measurements never arrived", $time, pending);
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20000000;
    $display("%0t: timeout", $time);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
design/uprb_pkg.sv
design/uprb_ram.sv
design/uprb_cordic.sv
design/unicycle_pose_range_bearing_top.sv
design/uprb_checker.sv
verif/uprb_checker.sv
verif/unicycle_pose_range_bearing_top_tb.sv
